[hdl/dqku_pkg.sv]
// Shared types and codes for the keyed-update double-ended queue.
package dqku_pkg;

    localparam int ID_W   = 16;
    localparam int NAME_W = 64;
    localparam int AGE_W  = 8;

    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_LIST       = 3'd2;
    localparam logic [2:0] OP_UPDATE     = 3'd3;
    localparam logic [2:0] OP_POP_FRONT  = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]        operation;
        logic [ID_W-1:0]   patient_id;
        logic [NAME_W-1:0] name_text;
        logic [AGE_W-1:0]  age;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   out_id;
        logic [NAME_W-1:0] out_name;
        logic [AGE_W-1:0]  out_age;
        logic              last;
    } out_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIST_RD,
        S_LIST_OUT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_REPLY
    } state_t;

endpackage

[hdl/dqku_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module dqku_ram #(
    parameter int WIDTH = 88,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/deque_with_keyed_update_top.sv]
// Top level of the bounded double-ended queue of records with keyed age update.
//
// The in channel takes one command word per handshake: push back, push front,
// list, update age or pop front. The out channel returns result words, each
// with a status and, for list and pop, the record; last marks the final word
// of a command. Records sit in one RAM addressed as a ring by head and count.
// Push commands and commands on an empty queue finish in the accept cycle.
// Pop reads and returns the front record; list walks every record and update
// walks until the key matches, each record taking a RAM read state and then an
// output or compare state. One command is handled at a time; in_ready is low
// while the sequencer walks the ring. A result word waits in the output
// register while out_ready is low, and the walk pauses until it is taken.
// Reset empties the queue and the output register; the RAM keeps no reset.
// Operation codes five to seven are dropped without a result.
module deque_with_keyed_update_top
    import dqku_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int NAME_BYTES = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int NM_W   = 8 * NAME_BYTES;
    localparam int REC_W  = ID_W + NM_W + AGE_W;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(DEPTH - 1);

    function automatic logic [IDX_W-1:0] wrap_slot(input logic [IDX_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        return IDX_W'(sum);
    endfunction

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             pop_reg, pop_next;
    logic [1:0]       reply_reg, reply_next;
    logic [ID_W-1:0]  key_id_reg;
    logic [AGE_W-1:0] key_age_reg;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_word_reg, out_word_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [REC_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic [REC_W-1:0] rd_data;
    logic [ID_W-1:0]  rd_id;
    logic [NM_W-1:0]  rd_name;
    logic [AGE_W-1:0] rd_age;

    logic             out_free;
    logic             accept;
    logic             full;
    logic             empty;
    logic             last_idx;
    logic [IDX_W-1:0] tail_addr;
    logic [IDX_W-1:0] front_addr;
    logic [REC_W-1:0] push_rec;

    dqku_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_id    = rd_data[REC_W-1 -: ID_W];
    assign rd_name  = rd_data[AGE_W +: NM_W];
    assign rd_age   = rd_data[AGE_W-1:0];
    assign rd_addr  = wrap_slot(head_reg, CNT_W'(idx_reg));

    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == S_IDLE) && out_free;
    assign accept     = in_valid && in_ready;
    assign full       = (count_reg == DEPTH_C);
    assign empty      = (count_reg == '0);
    assign last_idx   = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign tail_addr  = wrap_slot(head_reg, count_reg);
    assign front_addr = (head_reg == '0) ? TOP_IDX : head_reg - IDX_W'(1);
    assign push_rec   = {in_word.patient_id, in_word.name_text[NM_W-1:0], in_word.age};

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            pop_reg       <= 1'b0;
            reply_reg     <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pop_reg       <= pop_next;
            reply_reg     <= reply_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        if (accept)
        begin
            key_id_reg  <= in_word.patient_id;
            key_age_reg <= in_word.age;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pop_next       = pop_reg;
        reply_next     = reply_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        wr_en          = 1'b0;
        wr_addr        = tail_addr;
        wr_data        = push_rec;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_word_next = '0;
                    out_word_next.last = 1'b1;
                    unique case (in_word.operation)
                        OP_PUSH_BACK:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                            begin
                                out_word_next.status = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = tail_addr;
                                count_next = count_reg + CNT_W'(1);
                                out_word_next.status = ST_OK;
                            end
                        end
                        OP_PUSH_FRONT:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                            begin
                                out_word_next.status = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = front_addr;
                                head_next  = front_addr;
                                count_next = count_reg + CNT_W'(1);
                                out_word_next.status = ST_OK;
                            end
                        end
                        OP_LIST, OP_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                out_valid_next = 1'b1;
                                out_word_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                pop_next   = (in_word.operation == OP_POP_FRONT);
                                state_next = S_LIST_RD;
                            end
                        end
                        OP_UPDATE:
                        begin
                            if (empty)
                            begin
                                out_valid_next = 1'b1;
                                out_word_next.status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            out_word_next = out_word_reg;
                        end
                    endcase
                end
            end
            S_LIST_RD:
            begin
                state_next = S_LIST_OUT;
            end
            S_LIST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_word_next.status   = ST_OK;
                    out_word_next.out_id   = rd_id;
                    out_word_next.out_name = NAME_W'(rd_name);
                    out_word_next.out_age  = rd_age;
                    out_word_next.last     = pop_reg || last_idx;
                    if (pop_reg)
                    begin
                        head_next  = wrap_slot(head_reg, CNT_W'(1));
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_IDLE;
                    end
                    else if (last_idx)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_LIST_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (rd_id == key_id_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = rd_addr;
                    wr_data    = {rd_id, rd_name, key_age_reg};
                    reply_next = ST_OK;
                    state_next = S_REPLY;
                end
                else if (last_idx)
                begin
                    reply_next = ST_NOT_FOUND;
                    state_next = S_REPLY;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_word_next        = '0;
                    out_word_next.status = reply_reg;
                    out_word_next.last   = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
